// ===== rtl/pslc_pkg.sv =====
// ----------------------------------------------------------------------------
// pslc_pkg
// Types and constants shared by the panel serial link controller.
// ----------------------------------------------------------------------------
package pslc_pkg;

  localparam int unsigned ReplyDepthDef   = 16;
  localparam int unsigned SegmentCountDef = 16;
  localparam int unsigned QueueDepth      = 4;

  typedef enum logic [2:0] {
    FUNC_TX_BYTE    = 3'd0,
    FUNC_RX_ENABLE  = 3'd1,
    FUNC_ATN_REARM  = 3'd2,
    FUNC_ATN_EVENT  = 3'd3,
    FUNC_BYTE_EVENT = 3'd4,
    FUNC_ANALOG     = 3'd5,
    FUNC_SEGMENT    = 3'd6,
    FUNC_UNUSED     = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    KIND_LED       = 3'd0,
    KIND_SCHED_ATN = 3'd1,
    KIND_SCHED_B60 = 3'd2,
    KIND_SCHED_B120 = 3'd3,
    KIND_ATN       = 3'd4,
    KIND_RX_DATA   = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx_data;
    logic [6:0] vol_setting;
    logic [7:0] dial_position;
    logic [6:0] tempo_setting;
    logic [3:0] segment_index;
    logic [7:0] segment_bits;
    logic [7:0] segment_addr;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic       last;
  } out_t;

  // Classified request passed from front to back.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_PUT     = 3'd1,
    OP_ENQ     = 3'd2,
    OP_RX_EN   = 3'd3,
    OP_BYTE_EV = 3'd4
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] a0;
    logic [7:0] b0;
    logic [7:0] a1;
    logic [7:0] b1;
    logic [7:0] a2;
    logic [7:0] b2;
    logic [1:0] cnt;     // packets for OP_ENQ (1..3)
    kind_e      kind;
  } cmd_t;

  // Back-end state machine.
  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_WR   = 2'd1,
    B_READ = 2'd2,
    B_EMIT = 2'd3
  } bstate_e;

  localparam logic [7:0] ReplyHead  = 8'h18;
  localparam logic [7:0] VolAddr    = 8'hd2;
  localparam logic [7:0] DialAddr   = 8'h10;
  localparam logic [7:0] TempoAddr  = 8'h17;
  localparam logic [7:0] NoPath     = 8'hff;

  function automatic logic is_handshake(input logic [7:0] c);
    return c == 8'h1f || c == 8'h1d || c == 8'h1e || c == 8'h20 ||
           c == 8'he0 || c == 8'h29 || c == 8'hdd;
  endfunction

  // 255 - round(v*255/100), v clamped to 100.
  // Divide by 100 as multiply by 5243 and shift by 19; exact for p <= 25550.
  function automatic logic [7:0] vol_map(input logic [6:0] v);
    logic [6:0]  c;
    logic [14:0] p;
    logic [27:0] m;
    logic [7:0]  q;
    c = (v > 7'd100) ? 7'd100 : v;
    p = 15'(c) * 15'd255 + 15'd50;
    m = 28'(p) * 28'd5243;
    q = m[26:19];
    return 8'd255 - q;
  endfunction

endpackage

// ===== rtl/panel_serial_link_controller.sv =====
// ----------------------------------------------------------------------------
// panel_serial_link_controller
// Front-panel link controller: deframes host bytes, queues replies, scans.
//
// Input channel in_valid_i/in_ready_o carries one request (in_i). Output
// channel out_valid_o/out_ready_i carries result items (out_o); the last
// item caused by a request has last set. Requests causing no result give
// nothing on the output.
// The front accepts one request per cycle into a four-entry command queue
// while the queue has room. The back writes reply bytes one per cycle into
// the reply RAM and emits at most one result per cycle; a byte event first
// reads the RAM in a separate read state. The back works on one command at
// a time, and a command that queues packets is held until all are done.
// Every result leaves through the registered output, after the read state
// for a byte event and after the RAM writes for queued packets.
// After reset the frame position, queue counts and scan history are clear;
// the first analog scan only records values. When the receiver stalls, the
// output register holds and the command queue fills, then in_ready_o drops.
// ----------------------------------------------------------------------------
module panel_serial_link_controller #(
  parameter int unsigned ReplyDepth   = pslc_pkg::ReplyDepthDef,
  parameter int unsigned SegmentCount = pslc_pkg::SegmentCountDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pslc_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pslc_pkg::out_t out_o
);
  import pslc_pkg::*;

  logic fv, fr, bv, br;
  cmd_t fc, bc;

  pslc_front #(.SegmentCount(SegmentCount)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i,
    .cmd_valid_o (fv), .cmd_ready_i (fr), .cmd_o (fc)
  );

  pslc_fifo u_fifo (
    .clk_i, .rst_ni,
    .wvalid_i (fv), .wready_o (fr), .wdata_i (fc),
    .rvalid_o (bv), .rready_i (br), .rdata_o (bc)
  );

  pslc_back #(.ReplyDepth(ReplyDepth)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (bv), .cmd_ready_o (br), .cmd_i (bc),
    .out_valid_o, .out_ready_i, .out_o
  );
endmodule

// ===== rtl/pslc_ram.sv =====
// ----------------------------------------------------------------------------
// pslc_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module pslc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/pslc_front.sv =====
// ----------------------------------------------------------------------------
// pslc_front
// Accepts requests, tracks framing and scan history, emits classified commands.
// ----------------------------------------------------------------------------
module pslc_front #(
  parameter int unsigned SegmentCount = pslc_pkg::SegmentCountDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pslc_pkg::in_t   in_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output pslc_pkg::cmd_t  cmd_o
);
  import pslc_pkg::*;

  localparam int unsigned SegW = (SegmentCount > 1) ? $clog2(SegmentCount) : 1;

  logic [2:0] frame_pos_q, frame_pos_d;
  logic [7:0] pay1_q, pay1_d, pay2_q, pay2_d;
  logic [7:0] vol_prev_q, vol_prev_d, dial_prev_q, dial_prev_d;
  logic [6:0] tempo_prev_q, tempo_prev_d;
  logic       synced_q, synced_d;
  logic [7:0] seg_prev_q [SegmentCount];
  logic       acc;
  logic [7:0] vol, d7;
  logic [6:0] adj, tp1, tm1, diff;
  logic       up, vch, dch, tch, seg_ok;
  logic [1:0] n;
  logic [7:0] qa [3];
  logic [7:0] qb [3];
  logic [3:0] sidx;
  logic [SegW-1:0] seg_idx;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = acc;
  assign acc         = in_valid_i && cmd_ready_i;
  assign sidx        = in_i.segment_index;
  assign seg_idx     = SegW'(sidx);

  always_comb begin
    vol  = vol_map(in_i.vol_setting);
    adj  = (in_i.tempo_setting > 7'd100) ? in_i.tempo_setting - 7'd101
                                          : in_i.tempo_setting;
    // forward distance around the 101 ring
    diff = (adj >= tempo_prev_q) ? adj - tempo_prev_q : adj + 7'd101 - tempo_prev_q;
    up   = (diff <= 7'd50);
    tp1  = (tempo_prev_q == 7'd100) ? 7'd0 : tempo_prev_q + 7'd1;
    tm1  = (tempo_prev_q == 7'd0) ? 7'd100 : tempo_prev_q - 7'd1;
    vch  = synced_q && vol != vol_prev_q;
    dch  = synced_q && in_i.dial_position != dial_prev_q;
    tch  = synced_q && adj != tempo_prev_q;
    d7   = up ? 8'h01 : 8'hff;
    seg_ok = (32'(sidx) < SegmentCount) && in_i.segment_addr != NoPath &&
             in_i.segment_bits != seg_prev_q[seg_idx];

    // pack analog packets in order
    n = 2'd0;
    qa[0] = '0; qb[0] = '0; qa[1] = '0; qb[1] = '0; qa[2] = '0; qb[2] = '0;
    if (vch) begin
      qa[n] = VolAddr; qb[n] = vol; n = n + 2'd1;
    end
    if (dch) begin
      qa[n] = DialAddr; qb[n] = in_i.dial_position; n = n + 2'd1;
    end
    if (tch) begin
      qa[n] = TempoAddr; qb[n] = d7; n = n + 2'd1;
    end

    frame_pos_d  = frame_pos_q;
    pay1_d       = pay1_q;
    pay2_d       = pay2_q;
    vol_prev_d   = vol_prev_q;
    dial_prev_d  = dial_prev_q;
    tempo_prev_d = tempo_prev_q;
    synced_d     = synced_q;
    cmd_o        = '0;
    cmd_o.op     = OP_NONE;
    cmd_o.kind   = KIND_LED;

    case (func_e'(in_i.func))
      FUNC_TX_BYTE: begin
        if (frame_pos_q == 3'd2) pay1_d = in_i.tx_data;
        if (frame_pos_q == 3'd4) pay2_d = in_i.tx_data;
        frame_pos_d = frame_pos_q + 3'd1;
        if (frame_pos_q == 3'd6) begin
          frame_pos_d = 3'd0;
          if (is_handshake(pay1_q)) begin
            cmd_o.op  = OP_ENQ;
            cmd_o.cnt = 2'd1;
            cmd_o.a0  = ReplyHead;
          end else begin
            cmd_o.op   = OP_PUT;
            cmd_o.kind = KIND_LED;
            cmd_o.a0   = pay1_q;
            cmd_o.b0   = pay2_q;
          end
        end
      end
      FUNC_RX_ENABLE:  cmd_o.op = OP_RX_EN;
      FUNC_ATN_REARM: begin
        cmd_o.op = OP_PUT; cmd_o.kind = KIND_SCHED_ATN;
      end
      FUNC_ATN_EVENT: begin
        cmd_o.op = OP_PUT; cmd_o.kind = KIND_ATN;
      end
      FUNC_BYTE_EVENT: cmd_o.op = OP_BYTE_EV;
      FUNC_ANALOG: begin
        synced_d = 1'b1;
        if (!synced_q || vch) vol_prev_d = vol;
        if (!synced_q || dch) dial_prev_d = in_i.dial_position;
        if (!synced_q) tempo_prev_d = adj;
        else if (tch) tempo_prev_d = up ? tp1 : tm1;
        if (n != 2'd0) begin
          cmd_o.op = OP_ENQ;
          cmd_o.cnt = n;
        end
        cmd_o.a0 = qa[0]; cmd_o.b0 = qb[0];
        cmd_o.a1 = qa[1]; cmd_o.b1 = qb[1];
        cmd_o.a2 = qa[2]; cmd_o.b2 = qb[2];
      end
      FUNC_SEGMENT: begin
        if (seg_ok) begin
          cmd_o.op  = OP_ENQ;
          cmd_o.cnt = 2'd1;
          cmd_o.a0  = in_i.segment_addr;
          cmd_o.b0  = in_i.segment_bits;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos_q  <= '0;
      pay1_q       <= '0;
      pay2_q       <= '0;
      vol_prev_q   <= '0;
      dial_prev_q  <= '0;
      tempo_prev_q <= '0;
      synced_q     <= 1'b0;
      for (int i = 0; i < SegmentCount; i++) seg_prev_q[i] <= '0;
    end else if (acc) begin
      frame_pos_q  <= frame_pos_d;
      pay1_q       <= pay1_d;
      pay2_q       <= pay2_d;
      vol_prev_q   <= vol_prev_d;
      dial_prev_q  <= dial_prev_d;
      tempo_prev_q <= tempo_prev_d;
      synced_q     <= synced_d;
      if (func_e'(in_i.func) == FUNC_SEGMENT && seg_ok) begin
        seg_prev_q[seg_idx] <= in_i.segment_bits;
      end
    end
  end
endmodule

// ===== rtl/pslc_back.sv =====
// ----------------------------------------------------------------------------
// pslc_back
// Runs commands against the reply byte queue and emits result items.
// ----------------------------------------------------------------------------
module pslc_back #(
  parameter int unsigned ReplyDepth = pslc_pkg::ReplyDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  pslc_pkg::cmd_t  cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pslc_pkg::out_t  out_o
);
  import pslc_pkg::*;

  localparam int unsigned AW = $clog2(ReplyDepth);
  localparam int unsigned LW = $clog2(ReplyDepth + 1);

  bstate_e    state_q, state_d;
  logic [LW-1:0] len_q, len_d, pos_q, pos_d;
  logic [1:0] pk_q, pk_d;       // packet being queued
  logic       half_q, half_d;   // byte within packet
  logic       sched_q, sched_d; // owe a schedule-atn result
  logic [1:0] pend_q, pend_d;   // pending results: 0 none
  out_t       r0_q, r0_d, r1_q, r1_d;
  out_t       ob_q, ob_d;
  logic       ov_q, ov_d;
  logic       we;
  logic [7:0] wdata, rdata;
  logic [LW-1:0] wl;
  logic [7:0] pa, pb;

  always_comb begin
    case (pk_q)
      2'd0:    begin pa = cmd_i.a0; pb = cmd_i.b0; end
      2'd1:    begin pa = cmd_i.a1; pb = cmd_i.b1; end
      default: begin pa = cmd_i.a2; pb = cmd_i.b2; end
    endcase
  end

  pslc_ram #(.Width(8), .Depth(ReplyDepth)) u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (wl[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (pos_q[AW-1:0]),
    .rdata_o (rdata)
  );

  function automatic out_t mk(input kind_e k, input logic [7:0] a, input logic [7:0] b);
    out_t r;
    r.kind = k; r.byte_a = a; r.byte_b = b; r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    state_d = state_q; len_d = len_q; pos_d = pos_q; pk_d = pk_q;
    half_d = half_q; sched_d = sched_q; pend_d = pend_q;
    r0_d = r0_q; r1_d = r1_q; ob_d = ob_q; ov_d = ov_q;
    cmd_ready_o = 1'b0; we = 1'b0; wdata = half_q ? pb : pa; wl = len_q;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_PUT: begin
              r0_d = mk(kind_e'(cmd_i.kind), cmd_i.a0, cmd_i.b0);
              pend_d = 2'd1; state_d = B_EMIT; cmd_ready_o = 1'b1;
            end
            OP_RX_EN: begin
              cmd_ready_o = 1'b1;
              if (pos_q < len_q) begin
                r0_d = mk(KIND_SCHED_B60, 8'd0, 8'd0);
                pend_d = 2'd1; state_d = B_EMIT;
              end
            end
            OP_BYTE_EV: begin
              cmd_ready_o = 1'b1;
              if (pos_q < len_q) state_d = B_READ;
            end
            OP_ENQ: begin
              pk_d = 2'd0; half_d = 1'b0; sched_d = 1'b0;
              if (pos_q == len_q) begin
                pos_d = '0; len_d = '0;
              end
              state_d = B_WR;
            end
            default: cmd_ready_o = 1'b1;
          endcase
        end
      end
      B_WR: begin
        // one byte a cycle; command held until all packets are done
        if (!half_q && 32'(len_q) + 2 > ReplyDepth) begin
          if (pk_q + 2'd1 == cmd_i.cnt) begin
            cmd_ready_o = 1'b1;
            if (sched_q) begin
              r0_d = mk(KIND_SCHED_ATN, 8'd0, 8'd0);
              pend_d = 2'd1; state_d = B_EMIT;
            end else state_d = B_IDLE;
          end else pk_d = pk_q + 2'd1;
        end else begin
          we = 1'b1;
          len_d = len_q + LW'(1);
          if (!half_q) begin
            if (pos_q == len_q) sched_d = 1'b1;
            half_d = 1'b1;
          end else begin
            half_d = 1'b0;
            if (pk_q + 2'd1 == cmd_i.cnt) begin
              cmd_ready_o = 1'b1;
              if (sched_q) begin
                r0_d = mk(KIND_SCHED_ATN, 8'd0, 8'd0);
                pend_d = 2'd1; state_d = B_EMIT;
              end else state_d = B_IDLE;
            end else pk_d = pk_q + 2'd1;
          end
        end
      end
      B_READ: begin
        r0_d = mk(KIND_RX_DATA, rdata, 8'd0);
        pos_d = pos_q + LW'(1);
        if (pos_q + LW'(1) < len_q) begin
          r1_d = mk(KIND_SCHED_B120, 8'd0, 8'd0);
          pend_d = 2'd2;
        end else pend_d = 2'd1;
        state_d = B_EMIT;
      end
      B_EMIT: begin
        if (!ov_q || out_ready_i) begin
          ob_d = r0_q;
          ob_d.last = (pend_q == 2'd1);
          ov_d = 1'b1;
          r0_d = r1_q;
          pend_d = pend_q - 2'd1;
          if (pend_q == 2'd1) state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Multi-packet scheduling: a later packet never re-triggers once queue is busy,
  // and sched is only set by the first fitting packet written onto an empty queue.

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE; len_q <= '0; pos_q <= '0; pk_q <= '0;
      half_q <= 1'b0; sched_q <= 1'b0; pend_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; len_q <= len_d; pos_q <= pos_d; pk_q <= pk_d;
      half_q <= half_d; sched_q <= sched_d; pend_q <= pend_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d; r1_q <= r1_d; ob_q <= ob_d;
  end

  assign out_valid_o = ov_q;
  assign out_o       = ob_q;
endmodule

// ===== rtl/pslc_fifo.sv =====
// ----------------------------------------------------------------------------
// pslc_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module pslc_fifo #(
  parameter int unsigned Depth = pslc_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wvalid_i,
  output logic           wready_o,
  input  pslc_pkg::cmd_t wdata_i,
  output logic           rvalid_o,
  input  logic           rready_i,
  output pslc_pkg::cmd_t rdata_o
);
  import pslc_pkg::*;
  localparam int unsigned AW = $clog2(Depth);

  cmd_t            buf_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;
  logic            push, pop;

  assign wready_o = cnt_q != (AW+1)'(Depth);
  assign rvalid_o = cnt_q != '0;
  assign rdata_o  = buf_q[rp_q];
  assign push     = wvalid_i && wready_o;
  assign pop      = rvalid_o && rready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + AW'(1);
      if (pop)  rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= wdata_i;
  end
endmodule
